@@ hdl/bjc_pkg.sv @@
// Shared types, codes and constants of the batch job controller.
package bjc_pkg;

	// Record index width inside the latched fault word; the code takes the rest.
	localparam int INDEX_BITS = 24;
	localparam int CODE_W     = 32 - INDEX_BITS;

	localparam logic [INDEX_BITS-1:0] INDEX_ALL_ONES = '1;

	// Stream widths
	localparam int TUSER_IN_W  = 3;
	localparam int TDATA_IN_W  = 40;
	localparam int TDATA_OUT_W = 112;

	// Operation codes carried on the input tuser
	typedef enum logic [2:0] {
		OP_DOORBELL      = 3'd0,
		OP_CTRL_WRITE    = 3'd1,
		OP_FAULT_ACK     = 3'd2,
		OP_RECORD        = 3'd3,
		OP_QUIESCE_BEGIN = 3'd4,
		OP_QUIESCE_END   = 3'd5
	} bjc_op_t;

	// Job phases, one-hot
	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_BUSY     = 5'b00010,
		PH_DONE     = 5'b00100,
		PH_ERROR    = 5'b01000,
		PH_REJECTED = 5'b10000
	} bjc_phase_t;

	// Status flag masks
	localparam logic [3:0] ST_BUSY     = 4'b0001;
	localparam logic [3:0] ST_DONE     = 4'b0010;
	localparam logic [3:0] ST_ERROR    = 4'b0100;
	localparam logic [3:0] ST_REJECTED = 4'b1000;

	// Command words
	localparam logic [31:0] CMD_FIRST = 32'd1;
	localparam logic [31:0] CMD_LAST  = 32'd3;

	// Fault codes raised by the controller itself
	localparam logic [7:0] FC_ABORTED     = 8'd1;
	localparam logic [7:0] FC_REJECT_BUSY = 8'd2;
	localparam logic [7:0] FC_BAD_COMMAND = 8'd3;

	// Control word abort bit
	localparam int CTRL_ABORT_BIT = 0;

	// One input item
	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] value;
		logic [7:0]  record_fault;
	} bjc_item_t;

	// One result item, last member in the lowest bits
	typedef struct packed {
		logic [1:0]  active_kind;
		logic [31:0] ctrl_readback;
		logic        irq_error;
		logic        irq_done;
		logic [23:0] fault_index;
		logic [7:0]  fault_code;
		logic        status_rejected;
		logic        status_error;
		logic        status_done;
		logic        status_busy;
		logic        accepted;
	} bjc_result_t;

	localparam int RESULT_W = $bits(bjc_result_t);

endpackage

@@ hdl/bjc_core.sv @@
// Job state registers and the combinational update for one transfer.
module bjc_core
	import bjc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        item_fire,
	input  bjc_item_t   item,
	output bjc_result_t result,
	output logic [31:0] processed
);

	logic [31:0]           record_count_q;
	bjc_phase_t            phase_q, phase_d;
	logic [3:0]            status_q, status_d;
	logic [31:0]           done_count_q, done_count_d;
	logic [31:0]           job_total_q, job_total_d;
	logic [1:0]            job_kind_q, job_kind_d;
	logic [CODE_W-1:0]     fault_code_q, fault_code_d;
	logic [INDEX_BITS-1:0] fault_index_q, fault_index_d;
	logic [31:0]           ctrl_q, ctrl_d;
	logic                  quiesce_q, quiesce_d;
	logic                  accepted, irq_done, irq_error;
	logic [31:0]           count_inc;
	logic                  cmd_ok;

	assign count_inc = done_count_q + 32'd1;
	assign cmd_ok    = item.value inside {[CMD_FIRST:CMD_LAST]};

	// Next state for the item at the port
	always_comb begin
		phase_d       = phase_q;
		status_d      = status_q;
		done_count_d  = done_count_q;
		job_total_d   = job_total_q;
		job_kind_d    = job_kind_q;
		fault_code_d  = fault_code_q;
		fault_index_d = fault_index_q;
		ctrl_d        = ctrl_q;
		quiesce_d     = quiesce_q;
		accepted      = 1'b1;
		irq_done      = 1'b0;
		irq_error     = 1'b0;
		case (item.opcode)
			OP_DOORBELL: begin
				if (quiesce_q) begin
					accepted = 1'b0;
				end else if (phase_q == PH_ERROR || phase_q == PH_REJECTED) begin
					// ignored until the fault is acknowledged
				end else if (phase_q == PH_BUSY || !cmd_ok) begin
					phase_d       = PH_REJECTED;
					job_kind_d    = 2'd0;
					status_d      = ST_REJECTED;
					done_count_d  = 32'd0;
					fault_code_d  = CODE_W'(phase_q == PH_BUSY ? FC_REJECT_BUSY
										: FC_BAD_COMMAND);
					fault_index_d = INDEX_ALL_ONES;
					irq_error     = 1'b1;
				end else begin
					done_count_d  = 32'd0;
					fault_code_d  = '0;
					fault_index_d = '0;
					if (record_count_q == 32'd0) begin
						phase_d    = PH_DONE;
						job_kind_d = 2'd0;
						status_d   = ST_DONE;
						irq_done   = 1'b1;
					end else begin
						job_total_d = record_count_q;
						job_kind_d  = item.value[1:0];
						phase_d     = PH_BUSY;
						status_d    = ST_BUSY;
					end
				end
			end
			OP_CTRL_WRITE: begin
				ctrl_d = {item.value[31:1], 1'b0};
				if (item.value[CTRL_ABORT_BIT] && phase_q == PH_BUSY) begin
					phase_d       = PH_ERROR;
					job_kind_d    = 2'd0;
					status_d      = ST_DONE | ST_ERROR;
					fault_code_d  = CODE_W'(FC_ABORTED);
					fault_index_d = done_count_q[INDEX_BITS-1:0];
					irq_error     = 1'b1;
				end
			end
			OP_FAULT_ACK: begin
				if (item.value != 32'd0) begin
					status_d      = status_q & ~(ST_ERROR | ST_REJECTED);
					fault_code_d  = '0;
					fault_index_d = '0;
					if (phase_q == PH_ERROR) begin
						phase_d = PH_DONE;
					end else if (phase_q == PH_REJECTED) begin
						phase_d = PH_IDLE;
					end
				end
			end
			OP_RECORD: begin
				if (phase_q == PH_BUSY) begin
					if (item.record_fault != 8'd0) begin
						phase_d       = PH_ERROR;
						job_kind_d    = 2'd0;
						status_d      = ST_DONE | ST_ERROR;
						fault_code_d  = CODE_W'(item.record_fault);
						fault_index_d = done_count_q[INDEX_BITS-1:0];
						irq_error     = 1'b1;
					end else begin
						done_count_d = count_inc;
						if (count_inc >= job_total_q) begin
							phase_d       = PH_DONE;
							job_kind_d    = 2'd0;
							status_d      = ST_DONE;
							fault_code_d  = '0;
							fault_index_d = '0;
							irq_done      = 1'b1;
						end
					end
				end
			end
			OP_QUIESCE_BEGIN: quiesce_d = 1'b1;
			OP_QUIESCE_END:   quiesce_d = 1'b0;
			default: begin
			end
		endcase
	end

	// Result fields as seen after the update
	always_comb begin
		result.accepted        = accepted;
		result.status_busy     = status_d[0];
		result.status_done     = status_d[1];
		result.status_error    = status_d[2];
		result.status_rejected = status_d[3];
		result.fault_code      = 8'(fault_code_d);
		result.fault_index     = 24'(fault_index_d);
		result.irq_done        = irq_done;
		result.irq_error       = irq_error;
		result.ctrl_readback   = ctrl_d;
		result.active_kind     = job_kind_d;
	end

	// Processed count travels beside the struct
	assign processed = done_count_d;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q <= 32'd0;
		end else if (cfg_wr_en) begin
			record_count_q <= cfg_wr_data;
		end
	end

	// Job state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			status_q      <= 4'd0;
			done_count_q  <= 32'd0;
			job_total_q   <= 32'd0;
			job_kind_q    <= 2'd0;
			fault_code_q  <= '0;
			fault_index_q <= '0;
			ctrl_q        <= 32'd0;
			quiesce_q     <= 1'b0;
		end else if (item_fire) begin
			phase_q       <= phase_d;
			status_q      <= status_d;
			done_count_q  <= done_count_d;
			job_total_q   <= job_total_d;
			job_kind_q    <= job_kind_d;
			fault_code_q  <= fault_code_d;
			fault_index_q <= fault_index_d;
			ctrl_q        <= ctrl_d;
			quiesce_q     <= quiesce_d;
		end
	end

endmodule

@@ hdl/bjc_out_stage.sv @@
// Two-entry output stage: result register plus skid register.
module bjc_out_stage
	import bjc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  bjc_result_t in_result,
	input  logic [31:0] in_processed,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output bjc_result_t out_result,
	output logic [31:0] out_processed
);

	logic        out_valid_q, skid_valid_q;
	bjc_result_t out_res_q, skid_res_q;
	logic [31:0] out_proc_q, skid_proc_q;
	logic        out_load;

	assign in_ready      = !skid_valid_q;
	assign out_valid     = out_valid_q;
	assign out_result    = out_res_q;
	assign out_processed = out_proc_q;
	assign out_load      = out_ready || !out_valid_q;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_valid_q) begin
				out_res_q  <= skid_res_q;
				out_proc_q <= skid_proc_q;
			end else begin
				out_res_q  <= in_result;
				out_proc_q <= in_processed;
			end
		end else if (in_fire) begin
			skid_res_q  <= in_result;
			skid_proc_q <= in_processed;
		end
	end

endmodule

@@ hdl/batch_job_controller.sv @@
// Top level of the batch job controller.
// Each result is registered in the output stage; the core update is combinational.
// Throughput: one item per cycle while the skid register is empty.
// A two-entry output stage keeps the input side open for one result while the
// master side stalls. Reset clears all job state, the record count and both stages.
module batch_job_controller
	import bjc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [31:0]            cfg_wr_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [31:0] value, [39:32] record_fault
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
	// [2:0] opcode
	input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] accepted, [1] status_busy, [2] status_done, [3] status_error,
	// [4] status_rejected, [36:5] processed_records, [44:37] fault_code,
	// [68:45] fault_index, [69] irq_done, [70] irq_error, [102:71] ctrl_readback,
	// [104:103] active_kind, [111:105] zero
	output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

	bjc_item_t   item;
	bjc_result_t core_res, out_res;
	logic [31:0] core_proc, out_proc;
	logic        in_fire;

	assign in_fire           = s_axis_tvalid && s_axis_tready;
	assign item.opcode       = s_axis_tuser;
	assign item.value        = s_axis_tdata[31:0];
	assign item.record_fault = s_axis_tdata[39:32];

	bjc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_fire   (in_fire),
		.item        (item),
		.result      (core_res),
		.processed   (core_proc)
	);

	bjc_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.in_result     (core_res),
		.in_processed  (core_proc),
		.in_ready      (s_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_result    (out_res),
		.out_processed (out_proc)
	);

	// Pack the result fields, processed count between status and fault code
	assign m_axis_tdata = {
		(TDATA_OUT_W - RESULT_W - 32)'(0),
		out_res.active_kind,
		out_res.ctrl_readback,
		out_res.irq_error,
		out_res.irq_done,
		out_res.fault_index,
		out_res.fault_code,
		out_proc,
		out_res.status_rejected,
		out_res.status_error,
		out_res.status_done,
		out_res.status_busy,
		out_res.accepted
	};

endmodule

@@ hdl/bjc_checker.sv @@
// Port-level checks of the batch job controller, bound to the top level.
module bjc_checker
	import bjc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [TDATA_OUT_W-1:0] m_axis_tdata
);

	logic        busy, done, rejected, irq_d, irq_e;
	logic [1:0]  kind;
	logic [23:0] f_index;

	assign busy     = m_axis_tdata[1];
	assign done     = m_axis_tdata[2];
	assign rejected = m_axis_tdata[4];
	assign f_index  = m_axis_tdata[68:45];
	assign irq_d    = m_axis_tdata[69];
	assign irq_e    = m_axis_tdata[70];
	assign kind     = m_axis_tdata[104:103];

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Only one interrupt per transfer
	a_irq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(irq_d && irq_e))
		else $error("done and error interrupts together");

	// A running job always has a kind
	a_busy_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && busy |-> kind != 2'd0)
		else $error("busy with no job kind");

	// Done interrupt only with done status and not busy
	a_irq_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && irq_d |-> done && !busy)
		else $error("done interrupt with wrong status");

	// A rejection reports no record index
	a_rej_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && rejected |-> f_index == 24'(INDEX_ALL_ONES))
		else $error("rejection with a record index");

endmodule

bind batch_job_controller bjc_checker u_bjc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/tb.sv @@
// Testbench for the batch job controller: directed table, then random job traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bjc_pkg::*;

	localparam int ITEMS = 1700;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam logic [31:0] F_CODE_MASK = 32'((64'd1 << CODE_W) - 64'd1);
	localparam logic [31:0] F_IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

	// One input transfer
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] value;
		logic [7:0]  rfault;
	} job_item_t;

	// One status word as laid out on m_axis_tdata, top field first
	typedef struct packed {
		logic [6:0]  pad;
		logic [1:0]  kind;
		logic [31:0] ctrl;
		logic        irq_err;
		logic        irq_done;
		logic [23:0] f_idx;
		logic [7:0]  f_code;
		logic [31:0] processed;
		logic        rejected;
		logic        error;
		logic        done;
		logic        busy;
		logic        accepted;
	} job_status_t;

	// Directed row: optional record count write, the transfer, optional typed status
	typedef struct {
		bit          set_count;
		logic [31:0] count;
		job_item_t   item;
		bit          typed;
		job_status_t status;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [TDATA_IN_W-1:0] s_axis_tdata = '0;
	logic [TUSER_IN_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;

	batch_job_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Job state as the controller should hold it
	bjc_phase_t  jm_phase = PH_IDLE;
	logic [3:0]  jm_stat = '0;
	logic [31:0] jm_done = '0;
	logic [31:0] jm_total = '0;
	logic [1:0]  jm_kind = '0;
	logic [31:0] jm_fword = '0;
	logic [31:0] jm_ctrl = '0;
	logic        jm_quiesce = 1'b0;
	logic [31:0] jm_rec_count = '0;

	job_status_t pending_status[$];
	dir_row_t    dir_tab[$];

	int n_fail = 0;
	int n_sent = 0;
	int n_acted = 0;
	int n_checked = 0;
	int n_jobs_ok = 0;
	int n_jobs_err = 0;
	int n_jobs_rej = 0;
	int n_refused = 0;
	int burst_left = 0;
	int cycles = 0;

	function automatic logic [31:0] fault_word_of(logic [31:0] code, logic [31:0] idx);
		return ((code & F_CODE_MASK) << INDEX_BITS) | (idx & F_IDX_MASK);
	endfunction

	task automatic end_ok();
		jm_phase = PH_DONE;
		jm_kind = '0;
		jm_stat = ST_DONE;
		jm_fword = '0;
		n_jobs_ok++;
	endtask

	task automatic end_fault(logic [31:0] code);
		jm_phase = PH_ERROR;
		jm_kind = '0;
		jm_stat = ST_DONE | ST_ERROR;
		jm_fword = fault_word_of(code, jm_done);
		n_jobs_err++;
	endtask

	task automatic end_reject(logic [31:0] code);
		jm_phase = PH_REJECTED;
		jm_kind = '0;
		jm_stat = ST_REJECTED;
		jm_done = '0;
		jm_fword = fault_word_of(code, F_IDX_MASK);
		n_jobs_rej++;
	endtask

	// Advance the job state by one transfer and build the status word it yields
	task automatic step_job_model(input job_item_t it, output job_status_t r,
			output bit acted);
		logic acc, irq_d, irq_e;
		acc = 1'b1;
		irq_d = 1'b0;
		irq_e = 1'b0;
		acted = 1'b1;
		case (it.op)
			OP_DOORBELL: begin
				if (jm_quiesce) begin
					acc = 1'b0;
					n_refused++;
				end else if (jm_phase == PH_ERROR || jm_phase == PH_REJECTED) begin
					acted = 1'b0;
				end else if (jm_phase == PH_BUSY) begin
					end_reject(32'(FC_REJECT_BUSY));
					irq_e = 1'b1;
				end else if (it.value < CMD_FIRST || it.value > CMD_LAST) begin
					end_reject(32'(FC_BAD_COMMAND));
					irq_e = 1'b1;
				end else begin
					jm_stat = '0;
					jm_done = '0;
					jm_fword = '0;
					if (jm_rec_count == 0) begin
						end_ok();
						irq_d = 1'b1;
					end else begin
						jm_total = jm_rec_count;
						jm_kind = it.value[1:0];
						jm_phase = PH_BUSY;
						jm_stat = ST_BUSY;
					end
				end
			end
			OP_CTRL_WRITE: begin
				jm_ctrl = it.value;
				if (it.value[CTRL_ABORT_BIT]) begin
					jm_ctrl[CTRL_ABORT_BIT] = 1'b0;
					if (jm_phase == PH_BUSY) begin
						end_fault(32'(FC_ABORTED));
						irq_e = 1'b1;
					end
				end
			end
			OP_FAULT_ACK: begin
				if (it.value != 0) begin
					jm_stat &= ~(ST_ERROR | ST_REJECTED);
					jm_fword = '0;
					if (jm_phase == PH_ERROR)
						jm_phase = PH_DONE;
					else if (jm_phase == PH_REJECTED)
						jm_phase = PH_IDLE;
				end else begin
					acted = 1'b0;
				end
			end
			OP_RECORD: begin
				if (jm_phase != PH_BUSY) begin
					acted = 1'b0;
				end else if (it.rfault != 0) begin
					end_fault(32'(it.rfault));
					irq_e = 1'b1;
				end else begin
					jm_done = jm_done + 1;
					if (jm_done >= jm_total) begin
						end_ok();
						irq_d = 1'b1;
					end
				end
			end
			OP_QUIESCE_BEGIN: jm_quiesce = 1'b1;
			OP_QUIESCE_END: jm_quiesce = 1'b0;
			default: acted = 1'b0;
		endcase
		r = '0;
		r.accepted = acc;
		r.busy = |(jm_stat & ST_BUSY);
		r.done = |(jm_stat & ST_DONE);
		r.error = |(jm_stat & ST_ERROR);
		r.rejected = |(jm_stat & ST_REJECTED);
		r.processed = jm_done;
		r.f_code = 8'((jm_fword >> INDEX_BITS) & F_CODE_MASK);
		r.f_idx = 24'(jm_fword & F_IDX_MASK);
		r.irq_done = irq_d;
		r.irq_err = irq_e;
		r.ctrl = jm_ctrl;
		r.kind = jm_kind;
	endtask

	function automatic job_status_t status_word(logic acc, logic busy, logic done,
			logic err, logic rej, logic [31:0] proc, logic [7:0] fc, logic [23:0] fi,
			logic irqd, logic irqe, logic [31:0] ctrl, logic [1:0] kind);
		job_status_t s;
		s = '0;
		s.accepted = acc;
		s.busy = busy;
		s.done = done;
		s.error = err;
		s.rejected = rej;
		s.processed = proc;
		s.f_code = fc;
		s.f_idx = fi;
		s.irq_done = irqd;
		s.irq_err = irqe;
		s.ctrl = ctrl;
		s.kind = kind;
		return s;
	endfunction

	function automatic dir_row_t drow(bit set_count, logic [31:0] count, logic [2:0] op,
			logic [31:0] value, logic [7:0] rfault, bit typed, job_status_t status);
		dir_row_t d;
		d.set_count = set_count;
		d.count = count;
		d.item.op = op;
		d.item.value = value;
		d.item.rfault = rfault;
		d.typed = typed;
		d.status = status;
		return d;
	endfunction

	// Drive one transfer in bursts with random gaps; queue its status on acceptance
	task automatic send_item(input job_item_t it, input bit typed, input job_status_t st);
		job_status_t r;
		bit acted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.rfault, it.value};
		s_axis_tuser <= it.op;
		do @(posedge clk); while (!s_axis_tready);
		step_job_model(it, r, acted);
		pending_status.push_back(typed ? st : r);
		n_sent++;
		if (acted)
			n_acted++;
	endtask

	// Wait until every status word is back, then load the record count
	task automatic write_record_count(input logic [31:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		jm_rec_count = v;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			n_fail++;
		end
	endtask

	// Receiver readiness: the mode is redrawn at random intervals
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ((rx_tick % 5) < 3);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare every status transfer with the oldest expected one
	job_status_t exp_s, got_s;
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_s = m_axis_tdata;
			if (pending_status.size() == 0) begin
				$error("status transfer %0h with nothing expected", m_axis_tdata);
				n_fail++;
			end else begin
				exp_s = pending_status.pop_front();
				n_checked++;
				cmp_field("accepted", 32'(exp_s.accepted), 32'(got_s.accepted));
				cmp_field("status_busy", 32'(exp_s.busy), 32'(got_s.busy));
				cmp_field("status_done", 32'(exp_s.done), 32'(got_s.done));
				cmp_field("status_error", 32'(exp_s.error), 32'(got_s.error));
				cmp_field("status_rejected", 32'(exp_s.rejected), 32'(got_s.rejected));
				cmp_field("processed_records", exp_s.processed, got_s.processed);
				cmp_field("fault_code", 32'(exp_s.f_code), 32'(got_s.f_code));
				cmp_field("fault_index", 32'(exp_s.f_idx), 32'(got_s.f_idx));
				cmp_field("irq_done", 32'(exp_s.irq_done), 32'(got_s.irq_done));
				cmp_field("irq_error", 32'(exp_s.irq_err), 32'(got_s.irq_err));
				cmp_field("ctrl_readback", exp_s.ctrl, got_s.ctrl);
				cmp_field("active_kind", 32'(exp_s.kind), 32'(got_s.kind));
				cmp_field("padding", 32'(exp_s.pad), 32'(got_s.pad));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		job_item_t it;
		logic [31:0] rc;
		int plen, r, k;

		// Directed table
		dir_tab.push_back(drow(1, 0, OP_DOORBELL, 32'd1, 8'h00, 1,
			status_word(1, 0, 1, 0, 0, 0, 8'd0, 24'd0, 1, 0, 0, 0)));
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'd0, 8'h00, 1,
			status_word(1, 0, 0, 0, 1, 0, FC_BAD_COMMAND, INDEX_ALL_ONES, 0, 1, 0, 0)));
		// doorbell while rejected is dropped
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'd2, 8'h00, 1,
			status_word(1, 0, 0, 0, 1, 0, FC_BAD_COMMAND, INDEX_ALL_ONES, 0, 0, 0, 0)));
		dir_tab.push_back(drow(0, 0, OP_FAULT_ACK, 32'd0, 8'hFF, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_FAULT_ACK, 32'hFFFF_FFFF, 8'h00, 1,
			status_word(1, 0, 0, 0, 0, 0, 8'd0, 24'd0, 0, 0, 0, 0)));
		dir_tab.push_back(drow(0, 0, OP_QUIESCE_BEGIN, 32'h5A5A_A5A5, 8'hA5, 0, '0));
		// refused under quiesce
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'd3, 8'h00, 1,
			status_word(0, 0, 0, 0, 0, 0, 8'd0, 24'd0, 0, 0, 0, 0)));
		dir_tab.push_back(drow(0, 0, OP_QUIESCE_END, 32'hA5A5_5A5A, 8'h5A, 0, '0));
		dir_tab.push_back(drow(1, 32'hFFFF_FFFF, OP_DOORBELL, 32'd3, 8'h00, 1,
			status_word(1, 1, 0, 0, 0, 0, 8'd0, 24'd0, 0, 0, 0, 3)));
		dir_tab.push_back(drow(0, 0, OP_RECORD, 32'd0, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_RECORD, 32'hFFFF_FFFF, 8'h00, 0, '0));
		// doorbell while busy
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'd1, 8'h00, 1,
			status_word(1, 0, 0, 0, 1, 0, FC_REJECT_BUSY, INDEX_ALL_ONES, 0, 1, 0, 0)));
		dir_tab.push_back(drow(0, 0, OP_FAULT_ACK, 32'h8000_0000, 8'h00, 0, '0));
		dir_tab.push_back(drow(1, 3, OP_DOORBELL, 32'd2, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_RECORD, 32'd0, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_RECORD, 32'd0, 8'hFF, 1,
			status_word(1, 0, 1, 1, 0, 1, 8'hFF, 24'd1, 0, 1, 0, 0)));
		dir_tab.push_back(drow(0, 0, OP_FAULT_ACK, 32'd1, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'd1, 8'h00, 0, '0));
		// abort of a running job
		dir_tab.push_back(drow(0, 0, OP_CTRL_WRITE, 32'hFFFF_FFFF, 8'h00, 1,
			status_word(1, 0, 1, 1, 0, 0, FC_ABORTED, 24'd0, 0, 1, 32'hFFFF_FFFE, 0)));
		dir_tab.push_back(drow(0, 0, OP_FAULT_ACK, 32'd1, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_CTRL_WRITE, 32'd1, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_SPARE6, 32'hFFFF_FFFF, 8'hFF, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_SPARE7, 32'd0, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'hFFFF_FFFF, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_FAULT_ACK, 32'd2, 8'h00, 0, '0));
		dir_tab.push_back(drow(1, 1, OP_DOORBELL, 32'd1, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_RECORD, 32'd0, 8'h00, 0, '0));
		dir_tab.push_back(drow(0, 0, OP_DOORBELL, 32'd2, 8'h00, 0, '0));
		// engine code in the range the controller uses for its own faults
		dir_tab.push_back(drow(0, 0, OP_RECORD, 32'd0, 8'h02, 0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_count)
				write_record_count(dir_tab[i].count);
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].status);
		end

		// Random phases: drain, load a new record count, then a run of job traffic
		while (n_sent < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				rc = 32'd0;
			else if (r < 20)
				rc = 32'd1;
			else if (r < 60)
				rc = $urandom_range(2, 6);
			else if (r < 85)
				rc = $urandom_range(7, 40);
			else if (r < 90)
				rc = 32'hFFFF_FFFF;
			else
				rc = $urandom;
			write_record_count(rc);
			plen = $urandom_range(20, 80);
			for (k = 0; k < plen; k++) begin
				it.value = $urandom;
				it.rfault = 8'($urandom);
				it.op = 3'($urandom_range(0, 7));
				r = $urandom_range(0, 99);
				if (jm_quiesce && r < 35) begin
					it.op = OP_QUIESCE_END;
				end else if (jm_phase == PH_BUSY) begin
					if (r < 82) begin
						it.op = OP_RECORD;
						if ($urandom_range(0, 39) != 0)
							it.rfault = '0;
					end else if (r < 85) begin
						it.op = OP_CTRL_WRITE;
						it.value[CTRL_ABORT_BIT] = 1'b1;
					end else if (r < 88) begin
						it.op = OP_DOORBELL;
						it.value = $urandom_range(1, 3);
					end else if (r < 92) begin
						it.op = OP_CTRL_WRITE;
						it.value[CTRL_ABORT_BIT] = 1'b0;
					end
				end else if (jm_phase == PH_ERROR || jm_phase == PH_REJECTED) begin
					if (r < 55) begin
						it.op = OP_FAULT_ACK;
					end else if (r < 62) begin
						it.op = OP_FAULT_ACK;
						it.value = '0;
					end
				end else begin
					if (r < 55) begin
						it.op = OP_DOORBELL;
						it.value = $urandom_range(1, 3);
					end else if (r < 60) begin
						it.op = OP_DOORBELL;
					end else if (r < 63) begin
						it.op = OP_DOORBELL;
						it.value = '0;
					end
				end
				send_item(it, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d transfers (%0d with effect), compared %0d status words.",
			n_sent, n_acted, n_checked);
		$display("Jobs: %0d finished, %0d faulted or aborted, %0d rejected, %0d refused.",
			n_jobs_ok, n_jobs_err, n_jobs_rej, n_refused);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
